// ===== sv/rau_pkg.sv =====
`default_nettype none
package rau_pkg;
  localparam int OPERAND_BITS = 16;
  localparam int PROD_BITS = 2 * OPERAND_BITS;
  localparam int RES_NUM_BITS = 33;
  localparam int RES_DEN_BITS = 31;
  localparam int MAG_BITS = 32;
  localparam int CNT_BITS = 6;

  localparam logic [1:0] MODE_MAKE = 2'd0;
  localparam logic [1:0] MODE_ADD = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_CHECK, ST_GCD, ST_DIVN, ST_DIVD, ST_OUT
  } back_state_t;

  typedef struct packed {
    logic                       neg;
    logic                       zero_den;
    logic                       zero_num;
    logic [MAG_BITS-1:0]        nm;
    logic [MAG_BITS-1:0]        dm;
  } work_t;
endpackage
`default_nettype wire

// ===== sv/rau_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module rau_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire logic [rau_pkg::MAG_BITS-1:0] dividend,
  input  wire logic [rau_pkg::MAG_BITS-1:0] divisor,
  output logic                              done,
  output logic [rau_pkg::MAG_BITS-1:0]      quot,
  output logic [rau_pkg::MAG_BITS-1:0]      rem
);
  logic                              busy_r, busy_nxt;
  logic [rau_pkg::CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [rau_pkg::MAG_BITS-1:0]      q_r, q_nxt, d_r, d_nxt;
  logic [rau_pkg::MAG_BITS:0]        r_r, r_nxt, trial;
  logic                              done_r, done_nxt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    d_nxt = d_r;
    r_nxt = r_r;
    done_nxt = 1'b0;
    trial = {r_r[rau_pkg::MAG_BITS-1:0], q_r[rau_pkg::MAG_BITS-1]} - {1'b0, d_r};
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      q_nxt = dividend;
      d_nxt = divisor;
      r_nxt = '0;
    end else if (busy_r) begin
      if (trial[rau_pkg::MAG_BITS]) begin
        r_nxt = {r_r[rau_pkg::MAG_BITS-1:0], q_r[rau_pkg::MAG_BITS-1]};
        q_nxt = {q_r[rau_pkg::MAG_BITS-2:0], 1'b0};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[rau_pkg::MAG_BITS-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rau_pkg::CNT_BITS'(rau_pkg::MAG_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem = r_r[rau_pkg::MAG_BITS-1:0];

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy_r) else $error("divider did not start");
endmodule
`default_nettype wire

// ===== sv/rau_front.sv =====
`default_nettype none
// takes a request, registers operands into a one-entry queue
module rau_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_mode,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] in_a_num,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] in_a_den,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] in_b_num,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] in_b_den,
  output logic                                   q_valid,
  input  wire logic                              q_pop,
  output logic [1:0]                             q_mode,
  output logic signed [rau_pkg::OPERAND_BITS-1:0] q_a_num,
  output logic signed [rau_pkg::OPERAND_BITS-1:0] q_a_den,
  output logic signed [rau_pkg::OPERAND_BITS-1:0] q_b_num,
  output logic signed [rau_pkg::OPERAND_BITS-1:0] q_b_den
);
  logic valid_r, valid_nxt;
  logic [1:0] mode_r;
  logic signed [rau_pkg::OPERAND_BITS-1:0] an_r, ad_r, bn_r, bd_r;
  logic take;

  assign busy = valid_r;
  assign take = start && !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) valid_nxt = 1'b0;
    if (take) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
    if (take) begin
      // unused mode 3 behaves as make
      mode_r <= (in_mode == rau_pkg::MODE_RSVD) ? rau_pkg::MODE_MAKE : in_mode;
      an_r <= in_a_num;
      ad_r <= in_a_den;
      bn_r <= in_b_num;
      bd_r <= in_b_den;
    end
  end

  assign q_valid = valid_r;
  assign q_mode = mode_r;
  assign q_a_num = an_r;
  assign q_a_den = ad_r;
  assign q_b_num = bn_r;
  assign q_b_den = bd_r;

  a_take_fill: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> valid_r) else $error("queue not filled");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> valid_r) else $error("pop of empty queue");
  a_mode_ok: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> mode_r != rau_pkg::MODE_RSVD) else $error("mode 3 queued");
endmodule
`default_nettype wire

// ===== sv/rau_back.sv =====
`default_nettype none
// cross multiply, then Euclid on a shared divider, then two divides
module rau_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  output logic                                   q_pop,
  input  wire logic [1:0]                        q_mode,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] q_a_num,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] q_a_den,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] q_b_num,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] q_b_den,
  output logic                                   out_valid,
  output logic signed [rau_pkg::RES_NUM_BITS-1:0] out_res_num,
  output logic [rau_pkg::RES_DEN_BITS-1:0]       out_res_den,
  output logic                                   out_zero_den_error
);
  localparam int PB = rau_pkg::PROD_BITS;
  localparam int MB = rau_pkg::MAG_BITS;

  rau_pkg::back_state_t st_r, st_nxt;
  logic signed [PB-1:0] p1_r, p2_r, p3_r;
  logic signed [PB:0]   top_r, bot_r;
  logic [MB-1:0] nm_r, dm_r, gn_r, gd_r, g_r;
  logic neg_r;
  logic div_go, div_done;
  logic [MB-1:0] div_a, div_b, div_q, div_r;
  logic [MB-1:0] top_mag, bot_mag;
  logic valid_r;
  logic signed [rau_pkg::RES_NUM_BITS-1:0] num_r;
  logic [rau_pkg::RES_DEN_BITS-1:0] den_r;
  logic err_r;

  rau_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  assign top_mag = top_r[PB] ? MB'(-top_r) : MB'(top_r);
  assign bot_mag = bot_r[PB] ? MB'(-bot_r) : MB'(bot_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rau_pkg::ST_IDLE:  if (q_valid) st_nxt = rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1:  st_nxt = rau_pkg::ST_MUL2;
      rau_pkg::ST_MUL2:  st_nxt = rau_pkg::ST_CHECK;
      rau_pkg::ST_CHECK: st_nxt = (bot_r == '0 || top_r == '0) ? rau_pkg::ST_OUT
                                                               : rau_pkg::ST_GCD;
      rau_pkg::ST_GCD:   if (div_done && div_r == '0) st_nxt = rau_pkg::ST_DIVN;
      rau_pkg::ST_DIVN:  if (div_done) st_nxt = rau_pkg::ST_DIVD;
      rau_pkg::ST_DIVD:  if (div_done) st_nxt = rau_pkg::ST_OUT;
      rau_pkg::ST_OUT:   st_nxt = rau_pkg::ST_IDLE;
      default:           st_nxt = rau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    div_go = 1'b0;
    div_a = gn_r;
    div_b = gd_r;
    q_pop = 1'b0;
    case (st_r)
      rau_pkg::ST_MUL1:  q_pop = 1'b1;
      rau_pkg::ST_CHECK: begin
        div_go = !(bot_r == '0 || top_r == '0);
        div_a = top_mag;
        div_b = bot_mag;
      end
      rau_pkg::ST_GCD: begin
        div_go = div_done;
        div_a = gd_r;
        div_b = div_r;
        if (div_done && div_r == '0) begin
          div_a = nm_r;
          div_b = gd_r;
        end
      end
      rau_pkg::ST_DIVN: begin
        div_go = div_done;
        div_a = dm_r;
        div_b = g_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rau_pkg::ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      valid_r <= (st_r == rau_pkg::ST_OUT);
    end
    case (st_r)
      rau_pkg::ST_IDLE: begin
        p1_r <= PB'(q_a_num) * PB'(q_b_den);
        p2_r <= PB'(q_b_num) * PB'(q_a_den);
        p3_r <= PB'(q_a_den) * PB'(q_b_den);
      end
      rau_pkg::ST_MUL1: begin
        case (q_mode)
          rau_pkg::MODE_ADD: top_r <= (PB+1)'(p1_r) + (PB+1)'(p2_r);
          rau_pkg::MODE_MUL: top_r <= (PB+1)'(p1_r);
          default:           top_r <= (PB+1)'(q_a_num);
        endcase
        bot_r <= (q_mode == rau_pkg::MODE_MAKE) ? (PB+1)'(q_a_den) : (PB+1)'(p3_r);
        if (q_mode == rau_pkg::MODE_MUL) p2_r <= PB'(q_a_num) * PB'(q_b_num);
        else p2_r <= p1_r;
      end
      rau_pkg::ST_MUL2: begin
        if (q_mode == rau_pkg::MODE_MUL) top_r <= (PB+1)'(p2_r);
      end
      rau_pkg::ST_CHECK: begin
        nm_r <= top_mag;
        dm_r <= bot_mag;
        gd_r <= bot_mag;
        neg_r <= top_r[PB] ^ bot_r[PB];
        err_r <= (bot_r == '0);
        num_r <= '0;
        den_r <= rau_pkg::RES_DEN_BITS'(1);
      end
      rau_pkg::ST_GCD: begin
        if (div_done) begin
          if (div_r == '0) g_r <= gd_r;
          else begin
            gn_r <= gd_r;
            gd_r <= div_r;
          end
        end
      end
      rau_pkg::ST_DIVN: if (div_done)
        num_r <= neg_r ? -rau_pkg::RES_NUM_BITS'(div_q) : rau_pkg::RES_NUM_BITS'(div_q);
      rau_pkg::ST_DIVD: if (div_done) den_r <= rau_pkg::RES_DEN_BITS'(div_q);
      default: ;
    endcase
  end

  assign out_valid = valid_r;
  assign out_res_num = num_r;
  assign out_res_den = den_r;
  assign out_zero_den_error = err_r;

  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r) else $error("result strobe held");
  a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop) else $error("double pop");
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> den_r != '0) else $error("zero denominator out");
endmodule
`default_nettype wire

// ===== sv/rational_arithmetic_unit_top.sv =====
`default_nettype none
// Rational arithmetic unit: make, add or multiply 16-bit fractions and
// reduce the result by GCD, sign on the numerator.
// Input: raise start with in_mode and operands; the request is taken at a
// clock edge where start is high and busy is low. busy stays high while
// the one-entry front queue holds a request the back end has not taken.
// Back end: 16x16 cross products, formed in the IDLE and MUL1 states,
// zero checks, then Euclid's GCD on a shared restoring divider (one
// quotient bit per cycle), then numerator and denominator are each
// divided by the GCD. A zero numerator or denominator skips the divider.
// A new request queues in the front while the previous one is still in
// the back end.
// Output: out_valid is high for one cycle with out_res_num, out_res_den
// and out_zero_den_error; the receiver cannot stall. A zero denominator
// gives 0/1 with the error flag set.
// Reset (rst_n low, synchronous) empties the queue and idles the back end.
module rational_arithmetic_unit_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_mode,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] in_a_num,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] in_a_den,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] in_b_num,
  input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] in_b_den,
  output logic                                   out_valid,
  output logic signed [rau_pkg::RES_NUM_BITS-1:0] out_res_num,
  output logic [rau_pkg::RES_DEN_BITS-1:0]       out_res_den,
  output logic                                   out_zero_den_error
);
  logic q_valid, q_pop;
  logic [1:0] q_mode;
  logic signed [rau_pkg::OPERAND_BITS-1:0] q_a_num, q_a_den, q_b_num, q_b_den;

  rau_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .q_valid(q_valid), .q_pop(q_pop), .q_mode(q_mode),
    .q_a_num(q_a_num), .q_a_den(q_a_den), .q_b_num(q_b_num), .q_b_den(q_b_den)
  );

  rau_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
    .q_mode(q_mode), .q_a_num(q_a_num), .q_a_den(q_a_den),
    .q_b_num(q_b_num), .q_b_den(q_b_den),
    .out_valid(out_valid), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_zero_den_error(out_zero_den_error)
  );
endmodule
`default_nettype wire

// ===== bench/rational_arithmetic_unit_top_tb.sv =====
`default_nettype none
module rational_arithmetic_unit_top_tb;
  localparam int IDLE_LIMIT = 20000;  // cycles with neither an accept nor a result
  localparam int N_RANDOM   = 1630;
  localparam int TAIL_ITEMS = 150;    // last requests go in back to back

  typedef struct {
    logic [1:0]                              mode;
    logic signed [rau_pkg::OPERAND_BITS-1:0] a_num;
    logic signed [rau_pkg::OPERAND_BITS-1:0] a_den;
    logic signed [rau_pkg::OPERAND_BITS-1:0] b_num;
    logic signed [rau_pkg::OPERAND_BITS-1:0] b_den;
    bit                                      drain;  // hold until all results are back
    bit                                      tail;   // no idle gap after this one
  } frac_req_t;

  typedef struct {
    logic signed [rau_pkg::RES_NUM_BITS-1:0] num;
    logic [rau_pkg::RES_DEN_BITS-1:0]        den;
    logic                                    zden;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = '0;
  logic signed [rau_pkg::OPERAND_BITS-1:0] in_a_num = '0, in_a_den = '0;
  logic signed [rau_pkg::OPERAND_BITS-1:0] in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic signed [rau_pkg::RES_NUM_BITS-1:0] out_res_num;
  logic [rau_pkg::RES_DEN_BITS-1:0] out_res_den;
  logic out_zero_den_error;

  frac_req_t req_q[$];      // requests not yet driven
  frac_res_t fraction_q[$]; // reduced fractions still owed by the block
  frac_req_t cur;
  int errors = 0;
  int idle_cycles = 0;
  int gap = 0;

  rational_arithmetic_unit_top u_top (
    .clk, .rst_n, .start, .busy, .in_mode, .in_a_num, .in_a_den, .in_b_num,
    .in_b_den, .out_valid, .out_res_num, .out_res_den, .out_zero_den_error
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d", what, got, want);
  endtask

  // Cross-multiply, reject zero denominator, reduce by Euclid, sign on top.
  function automatic frac_res_t reduce_fraction(input frac_req_t r);
    frac_res_t res;
    longint an, ad, bn, bd, top, bottom, g, d, t;
    an = r.a_num; ad = r.a_den; bn = r.b_num; bd = r.b_den;
    case (r.mode)
      rau_pkg::MODE_ADD: begin
        top = an * bd + bn * ad;
        bottom = ad * bd;
      end
      rau_pkg::MODE_MUL: begin
        top = an * bn;
        bottom = ad * bd;
      end
      default: begin  // make, and the unused mode 3
        top = an;
        bottom = ad;
      end
    endcase
    res.num = '0;
    res.den = rau_pkg::RES_DEN_BITS'(1);
    res.zden = (bottom == 0);
    if (bottom != 0 && top != 0) begin
      g = (top < 0) ? -top : top;
      d = (bottom < 0) ? -bottom : bottom;
      while (g % d != 0) begin
        t = g % d;
        g = d;
        d = t;
      end
      t = ((top < 0) ? -top : top) / d;
      res.num = rau_pkg::RES_NUM_BITS'(((top < 0) != (bottom < 0)) ? -t : t);
      res.den = rau_pkg::RES_DEN_BITS'(((bottom < 0) ? -bottom : bottom) / d);
    end
    return res;
  endfunction

  function automatic logic signed [rau_pkg::OPERAND_BITS-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3, 4, 5: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_req(input logic [1:0] m, input int an, ad, bn, bd,
                         input bit drain, input bit tail);
    frac_req_t r;
    r.mode = m;
    r.a_num = rau_pkg::OPERAND_BITS'(an);
    r.a_den = rau_pkg::OPERAND_BITS'(ad);
    r.b_num = rau_pkg::OPERAND_BITS'(bn);
    r.b_den = rau_pkg::OPERAND_BITS'(bd);
    r.drain = drain; r.tail = tail;
    req_q.push_back(r);
  endtask

  // Driver: a request moves at a rising edge with start high and busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        fraction_q.push_back(reduce_fraction(cur));
        if (!cur.tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      end
      if (!start || !busy) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (req_q.size() > 0 && (!req_q[0].drain || fraction_q.size() == 0)) begin
          cur = req_q.pop_front();
          start <= 1'b1;
          in_mode <= cur.mode;
          in_a_num <= cur.a_num;
          in_a_den <= cur.a_den;
          in_b_num <= cur.b_num;
          in_b_den <= cur.b_den;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so each strobe is checked as it comes.
  always @(posedge clk) begin
    frac_res_t want;
    if (rst_n && out_valid) begin
      if (fraction_q.size() == 0) begin
        report("unexpected result", out_res_num, 0);
      end else begin
        want = fraction_q.pop_front();
        if (out_res_num !== want.num) report("res_num", out_res_num, want.num);
        if (out_res_den !== want.den) report("res_den", out_res_den, want.den);
        if (out_zero_den_error !== want.zden)
          report("zero_den_error", out_zero_den_error, want.zden);
      end
    end
  end

  // Watchdog on cycles where nothing moves in either direction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    // Directed: field extremes, each mode, zero denominators and numerators.
    add_req(rau_pkg::MODE_MAKE, 6, 4, 0, 0, 0, 0);
    add_req(rau_pkg::MODE_MAKE, -6, 4, 0, 0, 0, 0);
    add_req(rau_pkg::MODE_MAKE, 6, -4, 0, 0, 0, 0);
    add_req(rau_pkg::MODE_MAKE, -32768, -32768, 0, 0, 0, 0);
    add_req(rau_pkg::MODE_MAKE, 32767, -32768, 0, 0, 0, 0);
    add_req(rau_pkg::MODE_MAKE, 5, 0, 0, 0, 0, 0);
    add_req(rau_pkg::MODE_MAKE, 0, -7, 0, 0, 0, 0);
    add_req(rau_pkg::MODE_RSVD, -12, 18, 99, 0, 0, 0);
    add_req(rau_pkg::MODE_RSVD, 3, 0, 1, 1, 0, 0);
    add_req(rau_pkg::MODE_ADD, 1, 2, 1, 3, 0, 0);
    add_req(rau_pkg::MODE_ADD, 1, 2, -1, 2, 0, 0);
    add_req(rau_pkg::MODE_ADD, -32768, 1, -32768, 1, 0, 0);
    add_req(rau_pkg::MODE_ADD, -32768, -32768, -32768, -32768, 0, 0);
    add_req(rau_pkg::MODE_ADD, 32767, -32768, 32767, -32768, 0, 0);
    add_req(rau_pkg::MODE_ADD, 32767, 32767, -32768, 32767, 0, 0);
    add_req(rau_pkg::MODE_ADD, 1, 0, 1, 5, 0, 0);
    add_req(rau_pkg::MODE_ADD, 1, 5, 1, 0, 0, 0);
    add_req(rau_pkg::MODE_MUL, -32768, 1, -32768, 1, 0, 0);
    add_req(rau_pkg::MODE_MUL, 32767, -32768, 32767, -32768, 0, 0);
    add_req(rau_pkg::MODE_MUL, 0, 3, 5, 7, 0, 0);
    add_req(rau_pkg::MODE_MUL, 3, 4, 5, 0, 1, 0);
    add_req(rau_pkg::MODE_MUL, -3, 4, 4, -3, 0, 0);
    add_req(rau_pkg::MODE_MUL, 1, 1, 1, 1, 0, 0);
    add_req(rau_pkg::MODE_MUL, 17, 3, 9, 34, 0, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      add_req(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
              rand_operand(), rand_operand(), i == N_RANDOM / 2,
              i >= N_RANDOM - TAIL_ITEMS);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (req_q.size() == 0);
    @(posedge clk);
    wait (!start && fraction_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
